/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL of the quantizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define GBBQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that stays active through reset.
`define GBBQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gbbq_pkg.sv */
`default_nettype none

package gbbq_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W  = 32;
    localparam int BYTE_W    = 8;
    localparam int ROWLEN_W  = 13;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * SAMPLE_W;

    // Defaults for the top-level parameters.
    localparam int ADDR_BITS_DEF = 24;
    localparam int MAX_ROW_DEF   = 4096;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] GAIN_RESET = 32'h0001_0000;

    // One half in Q32.32.
    localparam logic signed [PROD_W-1:0] HALF_Q32 = 64'sh0000_0000_8000_0000;

    // Byte limits used by the clipping rule.
    localparam logic [BYTE_W-1:0] BYTE_MAX      = 8'd255;
    localparam logic [BYTE_W-1:0] BYTE_MAX_LESS = 8'd254;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN           = 3'd0,
        REG_BIAS           = 3'd1,
        REG_SRC_UNDEFINED  = 3'd2,
        REG_DST_UNDEFINED  = 3'd3,
        REG_ROW_LENGTH     = 3'd4,
        REG_DST_START      = 3'd5,
        REG_DST_COL_STRIDE = 3'd6,
        REG_DST_ROW_STRIDE = 3'd7
    } t_cfg_reg;

    // Turn a Q32.32 sum into the output byte: truncate toward zero, then
    // step away from the no-data byte or clip to the byte range.
    function automatic logic [BYTE_W-1:0] quantize_byte(
        input logic signed [PROD_W-1:0] sum,
        input logic [BYTE_W-1:0]        nd,
        input logic                     nodata
    );
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] q;
        logic                       nd_nz;
        logic [BYTE_W-1:0]          res;
        hi    = sum[PROD_W-1:SAMPLE_W];
        nd_nz = |nd;
        // Floor of a negative value with a fraction is one below truncation.
        if (sum[PROD_W-1] && (|sum[SAMPLE_W-1:0])) begin
            q = hi + 32'sd1;
        end else begin
            q = hi;
        end
        priority if (nodata) begin
            res = nd;
        end else if (q == $signed({{(SAMPLE_W-BYTE_W){1'b0}}, nd})) begin
            res = nd_nz ? (nd - 8'd1) : 8'd1;
        end else if (q[SAMPLE_W-1]) begin
            res = nd_nz ? 8'd0 : 8'd1;
        end else if (|q[SAMPLE_W-2:BYTE_W]) begin
            res = (nd == BYTE_MAX) ? BYTE_MAX_LESS : BYTE_MAX;
        end else begin
            res = q[BYTE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/gain_bias_byte_quantizer.sv */
// Gain/bias byte quantizer.
// Input channel: i_valid, o_stall, i_sample (signed Q16.16), i_first. A
// transaction completes at a clock edge with i_valid high and o_stall low.
// i_first restarts the destination walk at dst_start for that sample.
// Output channel: o_valid, i_stall, o_dst_address, o_byte_value, o_row_done;
// a transaction completes with o_valid high and i_stall low.
// Configuration: i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data. Ready is
// always high; write registers only while no sample is in flight.
// The path has three registers: the input register, the 32x32 multiply
// together with the address walk, and the add, rounding and byte clipping
// into the output register. While the receiver does not stall, one sample
// per cycle is taken and delivered; the multiplier stage sets the clock
// rate.
// When the receiver stalls with a result waiting, all three stages hold and
// o_stall rises in the same cycle; bubbles are not squeezed out.
// Synchronous reset empties the pipeline, restores the register defaults and
// resets the walk to address zero, column zero.
`default_nettype none
`include "assert_macros.svh"

module gain_bias_byte_quantizer
    import gbbq_pkg::*;
#(
    parameter int P_ADDR_BITS = ADDR_BITS_DEF,
    parameter int P_MAX_ROW   = MAX_ROW_DEF,
    localparam int CFG_W      = (P_ADDR_BITS > SAMPLE_W) ? P_ADDR_BITS : SAMPLE_W
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Sample input channel
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_W-1:0]    i_sample,
    input  wire logic                   i_first,
    // Result output channel
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [P_ADDR_BITS-1:0]      o_dst_address,
    output logic [BYTE_W-1:0]           o_byte_value,
    output logic                        o_row_done,
    // Configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    localparam int CNT_W  = (P_MAX_ROW > 1) ? $clog2(P_MAX_ROW) : 1;
    localparam int LEN_W  = (ROWLEN_W > $clog2(P_MAX_ROW + 1)) ?
                            ROWLEN_W : $clog2(P_MAX_ROW + 1);
    localparam int CMP_W  = LEN_W + 1;

    // Configuration registers
    logic [SAMPLE_W-1:0]    r_gain;
    logic [SAMPLE_W-1:0]    r_bias;
    logic [SAMPLE_W-1:0]    r_src_undefined;
    logic [BYTE_W-1:0]      r_dst_undefined;
    logic [ROWLEN_W-1:0]    r_row_length;
    logic [P_ADDR_BITS-1:0] r_dst_start;
    logic [P_ADDR_BITS-1:0] r_dst_col_stride;
    logic [P_ADDR_BITS-1:0] r_dst_row_stride;

    // Walk state
    logic [CNT_W-1:0]       r_col_count;
    logic [P_ADDR_BITS-1:0] r_row_base;
    logic [P_ADDR_BITS-1:0] r_cur_address;
    logic [CNT_W-1:0]       n_col_count;
    logic [P_ADDR_BITS-1:0] n_row_base;
    logic [P_ADDR_BITS-1:0] n_cur_address;

    // Pipeline registers
    logic                       r_v1;
    logic [SAMPLE_W-1:0]        r_sample1;
    logic                       r_first1;
    logic                       r_v2;
    logic signed [PROD_W-1:0]   r_prod2;
    logic                       r_nodata2;
    logic [P_ADDR_BITS-1:0]     r_addr2;
    logic                       r_done2;
    logic                       r_v3;
    logic [P_ADDR_BITS-1:0]     r_addr3;
    logic [BYTE_W-1:0]          r_byte3;
    logic                       r_done3;

    logic                       adv;
    logic [CMP_W-1:0]           len_raw;
    logic [CMP_W-1:0]           len_eff;
    logic [P_ADDR_BITS-1:0]     walk_base;
    logic [P_ADDR_BITS-1:0]     walk_cur;
    logic [CNT_W-1:0]           walk_cnt;
    logic [CMP_W-1:0]           walk_cnt_inc;
    logic                       walk_done;
    logic signed [PROD_W-1:0]   bias_q;
    logic signed [PROD_W-1:0]   sum3;

    // The whole pipeline moves unless a finished result is held back.
    assign adv         = !r_v3 || !i_stall;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain           <= GAIN_RESET;
            r_bias           <= '0;
            r_src_undefined  <= '0;
            r_dst_undefined  <= '0;
            r_row_length     <= ROWLEN_W'(1);
            r_dst_start      <= '0;
            r_dst_col_stride <= P_ADDR_BITS'(1);
            r_dst_row_stride <= P_ADDR_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GAIN:           r_gain           <= i_cfg_data[SAMPLE_W-1:0];
                REG_BIAS:           r_bias           <= i_cfg_data[SAMPLE_W-1:0];
                REG_SRC_UNDEFINED:  r_src_undefined  <= i_cfg_data[SAMPLE_W-1:0];
                REG_DST_UNDEFINED:  r_dst_undefined  <= i_cfg_data[BYTE_W-1:0];
                REG_ROW_LENGTH:     r_row_length     <= i_cfg_data[ROWLEN_W-1:0];
                REG_DST_START:      r_dst_start      <= i_cfg_data[P_ADDR_BITS-1:0];
                REG_DST_COL_STRIDE: r_dst_col_stride <= i_cfg_data[P_ADDR_BITS-1:0];
                REG_DST_ROW_STRIDE: r_dst_row_stride <= i_cfg_data[P_ADDR_BITS-1:0];
            endcase
        end
    end

    // Stage 1: input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sample1 <= i_sample;
            r_first1  <= i_first;
        end
    end

    // Row length in use: zero acts as one, long rows saturate.
    always_comb begin
        len_raw = CMP_W'(r_row_length);
        if (len_raw == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_raw > CMP_W'(P_MAX_ROW)) begin
            len_eff = CMP_W'(P_MAX_ROW);
        end else begin
            len_eff = len_raw;
        end
    end

    // Address walk for the sample in stage 1.
    always_comb begin
        walk_base    = r_first1 ? r_dst_start : r_row_base;
        walk_cur     = r_first1 ? r_dst_start : r_cur_address;
        walk_cnt     = r_first1 ? '0 : r_col_count;
        walk_cnt_inc = CMP_W'(walk_cnt) + CMP_W'(1);
        walk_done    = walk_cnt_inc >= len_eff;
        if (walk_done) begin
            n_row_base    = walk_base + r_dst_row_stride;
            n_cur_address = n_row_base;
            n_col_count   = '0;
        end else begin
            n_row_base    = walk_base;
            n_cur_address = walk_cur + r_dst_col_stride;
            n_col_count   = CNT_W'(walk_cnt_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count   <= '0;
            r_row_base    <= '0;
            r_cur_address <= '0;
        end else if (adv && r_v1) begin
            r_col_count   <= n_col_count;
            r_row_base    <= n_row_base;
            r_cur_address <= n_cur_address;
        end
    end

    // Stage 2: exact Q32.32 product, no-data match and address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod2   <= $signed(r_sample1) * $signed(r_gain);
            r_nodata2 <= (r_sample1 == r_src_undefined);
            r_addr2   <= walk_cur;
            r_done2   <= walk_done;
        end
    end

    // Stage 3: add bias and one half, round toward zero, clip to a byte.
    assign bias_q = {{(PROD_W-SAMPLE_W-16){r_bias[SAMPLE_W-1]}}, r_bias, 16'd0};
    assign sum3   = r_prod2 + bias_q + HALF_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_addr3 <= r_addr2;
            r_byte3 <= quantize_byte(sum3, r_dst_undefined, r_nodata2);
            r_done3 <= r_done2;
        end
    end

    assign o_valid       = r_v3;
    assign o_dst_address = r_addr3;
    assign o_byte_value  = r_byte3;
    assign o_row_done    = r_done3;

    // Checks on the pipeline and the byte mapping.
    `GBBQ_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")
    `GBBQ_ASSERT(a_accept_loads, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_v1, "accepted sample lost")
    `GBBQ_ASSERT(a_nodata_byte, i_clk, i_rst_n, (r_v2 && r_nodata2 && adv) |=> (o_byte_value == r_dst_undefined), "missing sample not mapped to no-data byte")
    `GBBQ_ASSERT(a_avoid_nodata, i_clk, i_rst_n, (r_v2 && !r_nodata2 && adv) |=> (o_byte_value != r_dst_undefined), "valid sample produced the no-data byte")

endmodule

`default_nettype wire

/* tb/gain_bias_byte_quantizer_tb.sv */
`timescale 1ns / 1ps

module gain_bias_byte_quantizer_tb
    import gbbq_pkg::*;
();

    localparam int CFG_W = (ADDR_BITS_DEF > SAMPLE_W) ? ADDR_BITS_DEF : SAMPLE_W;
    localparam int ADDR_W = ADDR_BITS_DEF;
    localparam int PIPE_DEPTH = 3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 88;
    localparam longint Q32_ONE = 64'sd4294967296;
    localparam int unsigned TIMEOUT_NS = 1_000_000;

    typedef struct {
        logic [SAMPLE_W-1:0] raw;
        logic                mark_first;
    } t_sample_item;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic              row_done;
    } t_byte_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  i_first = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [ADDR_W-1:0]     o_dst_address;
    logic [BYTE_W-1:0]     o_byte_value;
    logic                  o_row_done;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    // Samples waiting to be sent and byte writes waiting to come out.
    t_sample_item samples_to_send[$];
    t_byte_write  byte_writes_due[$];
    int           mismatch_count = 0;

    // Shadow copy of the configuration registers.
    logic signed [SAMPLE_W-1:0] gain_q;
    logic signed [SAMPLE_W-1:0] bias_q;
    logic signed [SAMPLE_W-1:0] src_undef_q;
    logic [BYTE_W-1:0]          nodata_byte;
    logic [ROWLEN_W-1:0]        row_len;
    logic [ADDR_W-1:0]          start_addr;
    logic [ADDR_W-1:0]          col_stride;
    logic [ADDR_W-1:0]          row_stride;

    // Shadow copy of the destination walk.
    int unsigned                col_count;
    logic [ADDR_W-1:0]          row_base;
    logic [ADDR_W-1:0]          walk_addr;

    gain_bias_byte_quantizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_first       (i_first),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dst_address (o_dst_address),
        .o_byte_value  (o_byte_value),
        .o_row_done    (o_row_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void reset_shadow();
        gain_q      = GAIN_RESET;
        bias_q      = '0;
        src_undef_q = '0;
        nodata_byte = '0;
        row_len     = ROWLEN_W'(1);
        start_addr  = '0;
        col_stride  = ADDR_W'(1);
        row_stride  = ADDR_W'(1);
        col_count   = 0;
        row_base    = '0;
        walk_addr   = '0;
    endfunction

    function automatic void apply_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_GAIN:           gain_q      = data[SAMPLE_W-1:0];
            REG_BIAS:           bias_q      = data[SAMPLE_W-1:0];
            REG_SRC_UNDEFINED:  src_undef_q = data[SAMPLE_W-1:0];
            REG_DST_UNDEFINED:  nodata_byte = data[BYTE_W-1:0];
            REG_ROW_LENGTH:     row_len     = data[ROWLEN_W-1:0];
            REG_DST_START:      start_addr  = data[ADDR_W-1:0];
            REG_DST_COL_STRIDE: col_stride  = data[ADDR_W-1:0];
            REG_DST_ROW_STRIDE: row_stride  = data[ADDR_W-1:0];
            default: ;
        endcase
    endfunction

    // Scale by gain, add bias and one half in Q32.32, truncate toward zero,
    // then step off the no-data byte or clip into the byte range.
    function automatic logic [BYTE_W-1:0] quantize_sample(input logic [SAMPLE_W-1:0] raw);
        longint scaled;
        longint whole;
        longint nd;
        nd = longint'(nodata_byte);
        if (raw == src_undef_q) begin
            return nodata_byte;
        end
        scaled = longint'($signed(raw)) * longint'(gain_q)
                 + longint'(bias_q) * 65536 + HALF_Q32;
        whole = scaled / Q32_ONE;
        if (whole == nd) begin
            whole = (nd > 0) ? nd - 1 : 1;
        end else if (whole < 0) begin
            whole = (nd > 0) ? 0 : 1;
        end else if (whole > longint'(BYTE_MAX)) begin
            whole = (nd == longint'(BYTE_MAX)) ? longint'(BYTE_MAX_LESS)
                                               : longint'(BYTE_MAX);
        end
        return whole[BYTE_W-1:0];
    endfunction

    // Advance the destination walk by one sample and form its byte write.
    function automatic t_byte_write next_byte_write(input logic [SAMPLE_W-1:0] raw,
                                                    input logic mark_first);
        t_byte_write w;
        int unsigned len;
        len = row_len;
        if (len == 0) len = 1;
        if (len > MAX_ROW_DEF) len = MAX_ROW_DEF;
        if (mark_first) begin
            row_base  = start_addr;
            walk_addr = row_base;
            col_count = 0;
        end
        w.addr     = walk_addr;
        w.row_done = (col_count + 1 >= len);
        if (w.row_done) begin
            row_base  = row_base + row_stride;
            walk_addr = row_base;
            col_count = 0;
        end else begin
            walk_addr = walk_addr + col_stride;
            col_count = col_count + 1;
        end
        w.value = quantize_sample(raw);
        return w;
    endfunction

    // Sample source: half of it values between -300 and 300, the rest values
    // near zero, no-data codes, values aimed at the no-data byte and raw noise.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0:       s = src_undef_q;
            1:       s = $urandom();
            2, 3:    s = {{(SAMPLE_W-16-BYTE_W){1'b0}}, nodata_byte, 16'h0000}
                         - bias_q + $urandom_range(0, 32'h0000_FFFF);
            4:       s = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: s = $urandom_range(0, 600 << 16) - (300 << 16);
        endcase
        return s;
    endfunction

    function automatic logic [CFG_W-1:0] random_gain();
        case ($urandom_range(0, 6))
            0, 1:    return GAIN_RESET;
            2:       return $urandom_range(0, 32'h0004_0000);
            3:       return -$urandom_range(0, 32'h0004_0000);
            4:       return $urandom();
            5:       return '0;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_bias();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 600 << 16) - (300 << 16);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_nodata();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return CFG_W'(BYTE_MAX);
            2:       return CFG_W'(BYTE_MAX_LESS);
            3:       return 1;
            4:       return $urandom();
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_row_length();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return MAX_ROW_DEF;
            2:       return $urandom();
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_stride();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return CFG_W'({ADDR_W{1'b1}});
            2:       return $urandom();
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // One register write transaction on the configuration channel.
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] bias,
                             input logic [CFG_W-1:0] src_nd, input logic [CFG_W-1:0] dst_nd,
                             input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] start,
                             input logic [CFG_W-1:0] cstride,
                             input logic [CFG_W-1:0] rstride);
        write_reg(REG_GAIN, gain);
        write_reg(REG_BIAS, bias);
        write_reg(REG_SRC_UNDEFINED, src_nd);
        write_reg(REG_DST_UNDEFINED, dst_nd);
        write_reg(REG_ROW_LENGTH, len);
        write_reg(REG_DST_START, start);
        write_reg(REG_DST_COL_STRIDE, cstride);
        write_reg(REG_DST_ROW_STRIDE, rstride);
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] raw, input logic mark_first);
        t_sample_item it;
        it.raw        = raw;
        it.mark_first = mark_first;
        samples_to_send.push_back(it);
    endtask

    task automatic load_random(input int count);
        for (int k = 0; k < count; k++) begin
            push_sample(random_sample(),
                        (k == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 11) == 0));
        end
    endtask

    // Wait until every sample is sent and every byte write has come out,
    // then let the pipeline drain before touching the registers.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (samples_to_send.size() != 0 || i_valid || byte_writes_due.size() != 0);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Sample driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : driver
        t_sample_item item;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_sample <= '0;
            i_first  <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                byte_writes_due.push_back(next_byte_write(i_sample, i_first));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0 || samples_to_send.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    item = samples_to_send.pop_front();
                    i_valid  <= 1'b1;
                    i_sample <= item.raw;
                    i_first  <= item.mark_first;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                               : $urandom_range(0, 12);
                        gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    // Result stall pattern: free-flowing, periodic, random and heavy spans.
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(4, 60);
            end else begin
                stall_span--;
            end
            stall_tick++;
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= (stall_tick % 5) < 2;
                2:       i_stall <= $urandom_range(0, 1) == 1;
                default: i_stall <= $urandom_range(0, 9) < 8;
            endcase
        end
    end

    // Compare each completed result transaction with the oldest expected write.
    always @(posedge i_clk) begin : monitor
        t_byte_write want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (byte_writes_due.size() == 0) begin
                $error("unexpected result: dst_address %h byte_value %h row_done %b",
                       o_dst_address, o_byte_value, o_row_done);
                mismatch_count++;
            end else begin
                want = byte_writes_due.pop_front();
                if (o_dst_address !== want.addr) begin
                    $error("dst_address: expected %h, actual %h", want.addr, o_dst_address);
                    mismatch_count++;
                end
                if (o_byte_value !== want.value) begin
                    $error("byte_value: expected %h, actual %h", want.value, o_byte_value);
                    mismatch_count++;
                end
                if (o_row_done !== want.row_done) begin
                    $error("row_done: expected %b, actual %b", want.row_done, o_row_done);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        reset_shadow();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the walk starts at zero without a first mark, the
        // no-data byte is zero so small results are bumped up to one.
        push_sample(32'h0001_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'hFFFF_0000, 1'b0);
        push_sample(32'hFFFE_0000, 1'b0);
        push_sample(32'h00FF_0000, 1'b0);
        push_sample(32'h0100_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0002_8000, 1'b1);
        push_sample(32'h0002_7FFF, 1'b0);
        wait_idle();

        // Negative gain with no-data byte 255: bump down, clip to 254 and 0,
        // and a walk that wraps the address space on short rows.
        write_all(32'hFFFF_0000, 32'h0080_0000, 32'h8000_0000, BYTE_MAX, 3,
                  24'hFF_FFFE, 24'hFF_FFFF, 24'h00_0100);
        push_sample(32'h8000_0000, 1'b1);
        push_sample(32'h0080_0000, 1'b0);
        push_sample(32'hFF81_0000, 1'b0);
        push_sample(32'hFF38_0000, 1'b0);
        push_sample(32'h00C8_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0001, 1'b0);
        push_sample(32'h0001_0000, 1'b1);
        wait_idle();

        // Register extremes, including a zero row length.
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                  {CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
        load_random(PHASE_ITEMS);
        wait_idle();

        write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, BYTE_MAX, MAX_ROW_DEF,
                  0, 0, 0);
        load_random(PHASE_ITEMS);
        wait_idle();

        // Random settings, each followed by a batch of samples.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_all(random_gain(), random_bias(), $urandom(), random_nodata(),
                      random_row_length(), $urandom(), random_stride(), random_stride());
            load_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #TIMEOUT_NS;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/gbbq_pkg.sv
rtl/gain_bias_byte_quantizer.sv
tb/gain_bias_byte_quantizer_tb.sv
